### rtl/efsa_pkg.sv
package efsa_pkg;

	// Field widths fixed by the interface.
	localparam int TIME_W    = 32;
	localparam int ITEM_W    = 16;
	localparam int COST_W    = 8;
	localparam int PROD_W    = ITEM_W + COST_W;
	localparam int SRV_IDX_W = 3;
	localparam int COUNT_W   = 4;
	localparam int COSTS_W   = 64;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_COSTS = 2'd1;

	// Write request into the free time store.
	typedef struct packed {
		logic                 en;
		logic [SRV_IDX_W-1:0] idx;
		logic [TIME_W-1:0]    data;
	} time_wr_t;

	// Per-item cost of one server from the packed cost register.
	function automatic logic [COST_W-1:0] cost_of(input logic [COSTS_W-1:0] costs,
			input logic [SRV_IDX_W-1:0] idx);
		logic [SRV_IDX_W+2:0] base;
		base = {idx, 3'b000};
		return costs[base +: COST_W];
	endfunction

endpackage

### rtl/efsa_time_store.sv
module efsa_time_store import efsa_pkg::*; #(
	parameter int SERVERS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  time_wr_t             wr,
	input  logic [SRV_IDX_W-1:0] rd_idx,
	output logic [TIME_W-1:0]    rd_data
);

	localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;

	logic [TIME_W-1:0] time_q [SERVERS];

	// Free time of each server, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SERVERS; i++) begin
				time_q[i] <= '0;
			end
		end else if (wr.en) begin
			time_q[wr.idx[IDX_W-1:0]] <= wr.data;
		end
	end

	// One server is read per cycle by the scan.
	assign rd_data = time_q[rd_idx[IDX_W-1:0]];

endmodule

### rtl/efsa_mac.sv
module efsa_mac import efsa_pkg::*; (
	input  logic              clk,
	input  logic              load,
	input  logic [ITEM_W-1:0] items,
	input  logic [COST_W-1:0] cost,
	input  logic [TIME_W-1:0] start,
	output logic [TIME_W-1:0] next_time
);

	logic [PROD_W-1:0] product_q;
	logic [TIME_W:0]   sum;

	// Job length is registered before the add.
	always_ff @(posedge clk) begin
		if (load) begin
			product_q <= PROD_W'(items) * PROD_W'(cost);
		end
	end

	// Saturating add onto the start time.
	always_comb begin
		sum       = {1'b0, start} + (TIME_W+1)'(product_q);
		next_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	end

endmodule

### rtl/earliest_free_server_assigner.sv
// Channel    Direction  Handshake            Payload
// request    in         in_valid / in_stall  item_count
// result     out        out_valid/out_stall  chosen_server, start_time, latest_start
// config     in         cfg_write            cfg_index, cfg_data
//
// A request runs from acceptance to the return to idle through the scan of the active servers,
// one server per cycle through the comparator, then a multiply state, an add state and a result
// state. The next request is taken once the block is back in idle.
// Only one request is in flight; in_stall is high from acceptance until its result is taken.
// Reset clears all free times, the running maximum and the registers to their defaults.
// A stalled result holds its fields until it is taken.
module earliest_free_server_assigner import efsa_pkg::*; #(
	parameter int SERVERS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ITEM_W-1:0]    item_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SRV_IDX_W-1:0] chosen_server,
	output logic [TIME_W-1:0]    start_time,
	output logic [TIME_W-1:0]    latest_start,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COSTS_W-1:0]   cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   server_count_q;
	logic [COSTS_W-1:0]   server_costs_q;
	logic [COUNT_W-1:0]   active;
	logic [SRV_IDX_W-1:0] last_idx;
	logic [SRV_IDX_W-1:0] last_q;
	logic [SRV_IDX_W-1:0] idx_q;
	logic [SRV_IDX_W-1:0] best_q;
	logic [TIME_W-1:0]    best_time_q;
	logic [TIME_W-1:0]    max_q;
	logic [ITEM_W-1:0]    items_q;
	logic [TIME_W-1:0]    rd_data;
	logic [TIME_W-1:0]    next_time;
	logic                 take;
	time_wr_t             wr;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= COUNT_W'(1);
			server_costs_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SERVER_COUNT: server_count_q <= cfg_data[COUNT_W-1:0];
				REG_SERVER_COSTS: server_costs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Number of active servers, clamped to the range one to SERVERS.
	always_comb begin
		if (server_count_q == '0) begin
			active = COUNT_W'(1);
		end else if (server_count_q > COUNT_W'(SERVERS)) begin
			active = COUNT_W'(SERVERS);
		end else begin
			active = server_count_q;
		end
		last_idx = SRV_IDX_W'(active - COUNT_W'(1));
	end

	// Shared comparator: the first server, or a strictly earlier one, becomes the best.
	assign take = (idx_q == '0) || (rd_data < best_time_q);

	// Write-back of the advanced free time.
	always_comb begin
		wr.en   = (state_q == ST_ADD);
		wr.idx  = best_q;
		wr.data = next_time;
	end

	efsa_time_store #(
		.SERVERS(SERVERS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (idx_q),
		.rd_data (rd_data)
	);

	efsa_mac u_mac (
		.clk       (clk),
		.load      (state_q == ST_MUL),
		.items     (items_q),
		.cost      (cost_of(server_costs_q, best_q)),
		.start     (best_time_q),
		.next_time (next_time)
	);

	// Sequencer: scan, multiply, add, then present the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			last_q  <= '0;
			max_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						last_q  <= last_idx;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == last_q) begin
						state_q <= ST_MUL;
					end else begin
						idx_q <= idx_q + SRV_IDX_W'(1);
					end
				end
				ST_MUL: begin
					if (best_time_q > max_q) begin
						max_q <= best_time_q;
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers of the request and the running best.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			items_q <= item_count;
		end
		if (state_q == ST_SCAN && take) begin
			best_q      <= idx_q;
			best_time_q <= rd_data;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = (state_q == ST_OUT);
	assign chosen_server = best_q;
	assign start_time    = best_time_q;
	assign latest_start  = max_q;

	// The running maximum never falls below the reported start time.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> latest_start >= start_time)
		else $error("latest_start below start_time");

	// The chosen server lies within the active set.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chosen_server <= last_q)
		else $error("chosen server outside active set");

	// Only one request is in flight at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("ready while a result is pending");

	// An accepted request closes the input until its result is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not closed after acceptance");

endmodule

### tb/earliest_free_server_assigner_tb.sv
`timescale 1ns / 1ps

module earliest_free_server_assigner_tb import efsa_pkg::*;;

	localparam int SERVERS        = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = SERVERS + 8;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_JOBS     = 70;
	localparam int SATURATE_JOBS  = 300;

	// Indexes beyond the register map; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [SRV_IDX_W-1:0] server;
		logic [TIME_W-1:0]    start;
		logic [TIME_W-1:0]    latest;
	} assignment_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [ITEM_W-1:0]    item_count   = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [SRV_IDX_W-1:0] chosen_server;
	logic [TIME_W-1:0]    start_time;
	logic [TIME_W-1:0]    latest_start;
	logic                 cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [COSTS_W-1:0]   cfg_data     = '0;

	// Shadow copy of the registers and the scheduling state.
	logic [COUNT_W-1:0] shadow_count;
	logic [COSTS_W-1:0] shadow_costs;
	logic [TIME_W-1:0]  shadow_free_time [SERVERS];
	logic [TIME_W-1:0]  shadow_latest;

	logic [ITEM_W-1:0] job_queue [$];
	assignment_t       predicted_assignments [$];

	int   sender_idle_pct    = 0;
	int   receiver_stall_pct = 0;
	int   error_count        = 0;
	int   quiet_cycles       = 0;
	logic watchdog_expired   = 1'b0;

	earliest_free_server_assigner #(
		.SERVERS(SERVERS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.item_count   (item_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.chosen_server(chosen_server),
		.start_time   (start_time),
		.latest_start (latest_start),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Greedy assignment of one job: earliest free active server, lowest index on a tie,
	// then a saturating advance of its free time.
	function automatic assignment_t assign_job(input logic [ITEM_W-1:0] items);
		int                 active;
		int                 best;
		int                 i;
		logic [COST_W-1:0]  cost;
		logic [63:0]        next_free;
		assignment_t        res;
		if (shadow_count == 0)
			active = 1;
		else if (shadow_count > SERVERS)
			active = SERVERS;
		else
			active = shadow_count;
		best = 0;
		for (i = 1; i < active; i++)
			if (shadow_free_time[i] < shadow_free_time[best])
				best = i;
		res.server = best[SRV_IDX_W-1:0];
		res.start  = shadow_free_time[best];
		if (res.start > shadow_latest)
			shadow_latest = res.start;
		res.latest = shadow_latest;
		cost = shadow_costs[best*COST_W +: COST_W];
		next_free = {32'd0, shadow_free_time[best]} + {48'd0, items} * {56'd0, cost};
		if (next_free > {32'd0, TIME_MAX})
			shadow_free_time[best] = TIME_MAX;
		else
			shadow_free_time[best] = next_free[TIME_W-1:0];
		return res;
	endfunction

	// Job sizes weighted towards the extremes.
	function automatic logic [ITEM_W-1:0] random_items();
		int          pick;
		logic [31:0] r;
		pick = $urandom_range(9);
		r = $urandom;
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		else if (pick == 2)
			return {12'd0, r[3:0]};
		return r[ITEM_W-1:0];
	endfunction

	// Random cost word with some servers at zero and some at the highest cost.
	function automatic logic [COSTS_W-1:0] random_costs();
		logic [COSTS_W-1:0] c;
		int                 b;
		int                 pick;
		c = {$urandom, $urandom};
		for (b = 0; b < SERVERS; b++) begin
			pick = $urandom_range(7);
			if (pick == 0)
				c[b*COST_W +: COST_W] = '0;
			else if (pick == 1)
				c[b*COST_W +: COST_W] = '1;
		end
		return c;
	endfunction

	// Count register word with random junk above the count field.
	function automatic logic [COSTS_W-1:0] count_word(input logic [COUNT_W-1:0] count);
		logic [COSTS_W-1:0] v;
		v = {$urandom, $urandom};
		v[COUNT_W-1:0] = count;
		return v;
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [COSTS_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_SERVER_COUNT: shadow_count = value[COUNT_W-1:0];
			REG_SERVER_COSTS: shadow_costs = value;
			default: ;
		endcase
	endtask

	// Wait until every queued job has been scheduled and its result taken.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (job_queue.size() != 0 || in_valid || predicted_assignments.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_stimulus();
		int          phase;
		int          n;
		logic [31:0] r;

		// Reset defaults: one server at zero cost, so its free time stays at zero.
		job_queue.push_back('1);
		job_queue.push_back('0);
		wait_idle();

		// A count of zero behaves as a single server.
		write_register(REG_SERVER_COUNT, count_word(4'd0));
		write_register(REG_SERVER_COSTS, '1);
		job_queue.push_back('1);
		job_queue.push_back(16'h0001);
		job_queue.push_back('0);
		wait_idle();

		// Writes to unused indexes must change neither the count nor the costs.
		write_register(REG_SPARE_2, 64'h8);
		write_register(REG_SPARE_3, 64'h8);
		job_queue.push_back(16'h0100);
		job_queue.push_back(16'h00FF);
		wait_idle();

		// A count above eight is clamped; equal free times go to the lowest index.
		write_register(REG_SERVER_COUNT, count_word(4'd15));
		write_register(REG_SERVER_COSTS, 64'h00FF_0001_8040_7F02);
		job_queue.push_back(16'h5555);
		job_queue.push_back(16'hAAAA);
		job_queue.push_back('1);
		job_queue.push_back(16'h0001);
		job_queue.push_back(16'h8000);
		job_queue.push_back(16'h7FFF);
		job_queue.push_back('0);
		job_queue.push_back(16'h1234);
		wait_idle();

		// Every server at zero cost: jobs are assigned but time does not move.
		write_register(REG_SERVER_COUNT, count_word(4'd8));
		write_register(REG_SERVER_COSTS, '0);
		job_queue.push_back('1);
		job_queue.push_back('0);
		wait_idle();

		write_register(REG_SERVER_COUNT, count_word(4'd2));
		write_register(REG_SERVER_COSTS, random_costs());
		job_queue.push_back(16'h00FF);
		job_queue.push_back(16'hFF00);
		job_queue.push_back('1);
		job_queue.push_back('0);
		wait_idle();

		// Random phases, each under a fresh register setting.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 4) begin
				sender_idle_pct    = 86;
				receiver_stall_pct = 33;
			end
			if (phase == 7) begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end
			case (phase)
				0: begin
					write_register(REG_SERVER_COUNT, count_word(4'd1));
					write_register(REG_SERVER_COSTS, random_costs());
				end
				1: begin
					write_register(REG_SERVER_COUNT, count_word(4'd8));
					write_register(REG_SERVER_COSTS, random_costs());
				end
				2: begin
					write_register(REG_SERVER_COUNT,
						count_word(COUNT_W'($urandom_range(15))));
					write_register(REG_SERVER_COSTS, '1);
				end
				3: begin
					write_register(REG_SERVER_COUNT,
						count_word(COUNT_W'($urandom_range(15))));
					write_register(REG_SERVER_COSTS, '0);
				end
				default: begin
					write_register(REG_SERVER_COUNT,
						count_word(COUNT_W'($urandom_range(15))));
					write_register(REG_SERVER_COSTS, random_costs());
				end
			endcase
			for (n = 0; n < PHASE_JOBS; n++)
				job_queue.push_back(random_items());
			wait_idle();
		end

		// Long jobs at the highest cost on one server drive its free time into saturation.
		write_register(REG_SERVER_COUNT, count_word(4'd1));
		write_register(REG_SERVER_COSTS, '1);
		for (n = 0; n < SATURATE_JOBS; n++) begin
			r = $urandom;
			job_queue.push_back({4'hF, r[11:0]});
		end
		job_queue.push_back('0);
		job_queue.push_back('1);
		wait_idle();

		// With the first server saturated the others take the work.
		write_register(REG_SERVER_COUNT, count_word(4'd3));
		write_register(REG_SERVER_COSTS, random_costs());
		for (n = 0; n < 30; n++)
			job_queue.push_back(random_items());
		wait_idle();
	endtask

	// Request driver: presents queued jobs, idling at random between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predicted_assignments.push_back(assign_job(item_count));
			if (!in_valid || !in_stall) begin
				if (job_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid   <= 1'b1;
					item_count <= job_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each result with the oldest prediction and stalls at random.
	always @(posedge clk) begin
		assignment_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_assignments.size() == 0) begin
					$display("%0t: unexpected result server %0d start %0d latest %0d",
						$time, chosen_server, start_time, latest_start);
					error_count++;
				end else begin
					want = predicted_assignments.pop_front();
					if (chosen_server !== want.server) begin
						$display("%0t: chosen_server expected %0d actual %0d",
							$time, want.server, chosen_server);
						error_count++;
					end
					if (start_time !== want.start) begin
						$display("%0t: start_time expected %0d actual %0d",
							$time, want.start, start_time);
						error_count++;
					end
					if (latest_start !== want.latest) begin
						$display("%0t: latest_start expected %0d actual %0d",
							$time, want.latest, latest_start);
						error_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Watchdog: too long without any request or result moving ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT)
				watchdog_expired <= 1'b1;
		end
	end

	initial begin
		int i;
		shadow_count  = 4'd1;
		shadow_costs  = '0;
		shadow_latest = '0;
		for (i = 0; i < SERVERS; i++)
			shadow_free_time[i] = '0;
		sender_idle_pct    = 33;
		receiver_stall_pct = 86;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		fork
			run_stimulus();
			wait (watchdog_expired);
		join_any
		disable fork;

		if (watchdog_expired)
			$display("%0t: timeout, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
		if (error_count == 0 && !watchdog_expired)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
rtl/efsa_pkg.sv
rtl/efsa_time_store.sv
rtl/efsa_mac.sv
rtl/earliest_free_server_assigner.sv
tb/earliest_free_server_assigner_tb.sv
